FILE: rtl/core/eig2_pkg.sv
// eig2_pkg: widths, saturation limits and the square-root cell payload type
// shared by every module of the 2x2 integer eigenvalue block.
// no dependencies.
package eig2_pkg;

	localparam int ENTRY_BITS = 16;
	localparam int OUT_W      = 18;

	localparam int DIFF_W  = ENTRY_BITS + 1;
	localparam int TR_W    = ENTRY_BITS + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int BC_W    = 2 * ENTRY_BITS;
	localparam int DISC_W  = 2 * ENTRY_BITS + 3;
	localparam int ROOT_W  = ENTRY_BITS + 1;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int REM_W   = ROOT_W + 1;
	localparam int NP_W    = ENTRY_BITS + 3;
	localparam int SAT_W   = (NP_W > OUT_W) ? NP_W : OUT_W;
	localparam int LATENCY = ROOT_W + 3;

	localparam logic signed [SAT_W-1:0] ROOT_MAX = SAT_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [SAT_W-1:0] ROOT_MIN = SAT_W'(-(1 << (OUT_W - 1)));

	// what travels down the square-root chain, one transaction per cell
	typedef struct packed {
		logic [RAD_W-1:0]       rad;
		logic [REM_W-1:0]       rem;
		logic [ROOT_W-1:0]      root;
		logic signed [TR_W-1:0] tr;
		logic                   cplx;
	} sq_data_t;

endpackage

FILE: rtl/core/eig2_front.sv
// eig2_front: two pipeline stages forming the trace and the discriminant
// (a-d)^2 + 4bc, which equals trace^2 - 4*det. depends on eig2_pkg.
module eig2_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic signed [eig2_pkg::ENTRY_BITS-1:0] top_left,
	input  logic signed [eig2_pkg::ENTRY_BITS-1:0] top_right,
	input  logic signed [eig2_pkg::ENTRY_BITS-1:0] bottom_left,
	input  logic signed [eig2_pkg::ENTRY_BITS-1:0] bottom_right,
	output logic                                   out_valid,
	output eig2_pkg::sq_data_t                     out_data
);
	import eig2_pkg::*;

	logic signed [DIFF_W-1:0] diff;
	logic signed [TR_W-1:0]   sum;
	logic signed [SQ_W-1:0]   sq_s1;
	logic signed [BC_W-1:0]   bc_s1;
	logic signed [TR_W-1:0]   tr_s1;
	logic signed [TR_W-1:0]   tr_s2;
	logic                     valid_s1;
	logic                     valid_s2;
	logic [DISC_W-1:0]        disc;
	logic [RAD_W-1:0]         rad_s2;
	logic                     cplx_s2;

	assign diff = $signed({top_left[ENTRY_BITS-1], top_left})
		- $signed({bottom_right[ENTRY_BITS-1], bottom_right});
	assign sum  = $signed({top_left[ENTRY_BITS-1], top_left})
		+ $signed({bottom_right[ENTRY_BITS-1], bottom_right});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= diff * diff;
		bc_s1 <= top_right * bottom_left;
		tr_s1 <= sum;
	end

	assign disc = {sq_s1[SQ_W-1], sq_s1} + {bc_s1[BC_W-1], bc_s1, 2'b00};

	always_ff @(posedge clk) begin
		tr_s2   <= tr_s1;
		cplx_s2 <= disc[DISC_W-1];
		// negative discriminant: root of zero keeps the chain harmless
		rad_s2  <= disc[DISC_W-1] ? '0 : disc[RAD_W-1:0];
	end

	assign out_valid     = valid_s2;
	assign out_data.rad  = rad_s2;
	assign out_data.rem  = '0;
	assign out_data.root = '0;
	assign out_data.tr   = tr_s2;
	assign out_data.cplx = cplx_s2;

endmodule

FILE: rtl/core/eig2_sqrt_cell.sv
// eig2_sqrt_cell: one restoring square-root step, settles one root bit and
// hands its partial remainder and root to the next cell. depends on eig2_pkg.
module eig2_sqrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  eig2_pkg::sq_data_t in_data,
	output logic               out_valid,
	output eig2_pkg::sq_data_t out_data
);
	import eig2_pkg::*;

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] rem_sub;
	logic             ge;
	sq_data_t         nxt;
	sq_data_t         data_q;
	logic             valid_q;

	always_comb begin
		rem_sh   = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
		trial    = {1'b0, in_data.root, 2'b01};
		ge       = rem_sh >= trial;
		rem_sub  = rem_sh - trial;
		nxt      = in_data;
		nxt.rad  = {in_data.rad[RAD_W-3:0], 2'b00};
		nxt.rem  = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
		nxt.root = {in_data.root[ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

FILE: rtl/core/eig2_back.sv
// eig2_back: turns trace, integer root and remainder into the two truncated
// eigenvalues, saturates them and registers the result. depends on eig2_pkg.
module eig2_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  eig2_pkg::sq_data_t                in_data,
	output logic                              done,
	output logic signed [eig2_pkg::OUT_W-1:0] larger_root,
	output logic signed [eig2_pkg::OUT_W-1:0] smaller_root,
	output logic                              complex_flag,
	output logic                              exact_flag
);
	import eig2_pkg::*;

	localparam logic signed [NP_W-1:0] ONE  = NP_W'(1);
	localparam logic signed [NP_W-1:0] ZERO = '0;

	function automatic logic [OUT_W-1:0] sat(input logic signed [NP_W-1:0] v);
		logic signed [SAT_W-1:0] w;
		w = SAT_W'(v);
		if (w > ROOT_MAX) begin
			w = ROOT_MAX;
		end else if (w < ROOT_MIN) begin
			w = ROOT_MIN;
		end
		return w[OUT_W-1:0];
	endfunction

	logic signed [NP_W-1:0]  tr_x;
	logic signed [NP_W-1:0]  s_x;
	logic signed [NP_W-1:0]  np;
	logic signed [NP_W-1:0]  nm;
	logic signed [NP_W-1:0]  big_h;
	logic signed [NP_W-1:0]  small_h;
	logic                    exact;
	logic                    neg_p;
	logic                    nonpos_m;
	logic                    done_q;
	logic                    cplx_q;
	logic                    exact_q;
	logic [OUT_W-1:0]        big_q;
	logic [OUT_W-1:0]        small_q;

	always_comb begin
		tr_x     = NP_W'(in_data.tr);
		s_x      = $signed({2'b00, in_data.root});
		np       = tr_x + s_x;
		nm       = tr_x - s_x;
		exact    = !in_data.cplx && (in_data.rem == '0);
		neg_p    = np[NP_W-1];
		nonpos_m = nm[NP_W-1] || (nm == ZERO);
		if (exact) begin
			// integer root: plain truncation toward zero
			big_h   = (np + (neg_p ? ONE : ZERO)) >>> 1;
			small_h = (nm + (nm[NP_W-1] ? ONE : ZERO)) >>> 1;
		end else begin
			// irrational root: true value lies strictly between integers
			big_h   = (np >>> 1) + (neg_p ? ONE : ZERO);
			small_h = ((nm - ONE) >>> 1) + (nonpos_m ? ONE : ZERO);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		cplx_q  <= in_data.cplx;
		exact_q <= exact;
		big_q   <= in_data.cplx ? '0 : sat(big_h);
		small_q <= in_data.cplx ? '0 : sat(small_h);
	end

	assign done         = done_q;
	assign larger_root  = $signed(big_q);
	assign smaller_root = $signed(small_q);
	assign complex_flag = cplx_q;
	assign exact_flag   = exact_q;

endmodule

FILE: rtl/core/eigenvalues_2x2_integer_top.sv
// Eigenvalues of a 2x2 signed integer matrix. A matrix is taken on every
// clock edge where start is high and busy is low. busy is high while reset
// is applied and stays high until the first clock edge after reset is
// released, so one matrix per cycle can stream in. Each result appears on
// the result ports, marked by done, for exactly one cycle. Each matrix
// passes the pipeline in order: two stages form the discriminant, one cell
// per root bit works out the integer square root, and a last stage rounds
// and saturates.
// Results come out in the order the matrices went in; the receiver cannot
// stall them, so it must take each one in the cycle that done is high.
// A negative discriminant gives complex_flag with both roots zero.
// depends on eig2_pkg, eig2_front, eig2_sqrt_cell and eig2_back.
module eigenvalues_2x2_integer_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [eig2_pkg::ENTRY_BITS-1:0] top_left,
	input  logic signed [eig2_pkg::ENTRY_BITS-1:0] top_right,
	input  logic signed [eig2_pkg::ENTRY_BITS-1:0] bottom_left,
	input  logic signed [eig2_pkg::ENTRY_BITS-1:0] bottom_right,
	output logic                                   done,
	output logic signed [eig2_pkg::OUT_W-1:0]      larger_root,
	output logic signed [eig2_pkg::OUT_W-1:0]      smaller_root,
	output logic                                   complex_flag,
	output logic                                   exact_flag
);
	import eig2_pkg::*;

	logic     busy_q;
	logic     cell_valid [ROOT_W+1];
	sq_data_t cell_data  [ROOT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	eig2_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start && !busy_q),
		.top_left     (top_left),
		.top_right    (top_right),
		.bottom_left  (bottom_left),
		.bottom_right (bottom_right),
		.out_valid    (cell_valid[0]),
		.out_data     (cell_data[0])
	);

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		eig2_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cell_valid[i]),
			.in_data   (cell_data[i]),
			.out_valid (cell_valid[i+1]),
			.out_data  (cell_data[i+1])
		);
	end

	eig2_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (cell_valid[ROOT_W]),
		.in_data      (cell_data[ROOT_W]),
		.done         (done),
		.larger_root  (larger_root),
		.smaller_root (smaller_root),
		.complex_flag (complex_flag),
		.exact_flag   (exact_flag)
	);

endmodule

FILE: rtl/core/eig2_checker.sv
// eig2_checker: port-level checks on the eigenvalue block, bound to the top
// level at the end of this file. depends on eig2_pkg.
module eig2_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [eig2_pkg::OUT_W-1:0] larger_root,
	input logic signed [eig2_pkg::OUT_W-1:0] smaller_root,
	input logic                              complex_flag,
	input logic                              exact_flag
);
	import eig2_pkg::*;

	// every result answers a transaction taken a fixed latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching transaction");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> !busy)
		else $error("busy after reset settled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(complex_flag && exact_flag))
		else $error("complex and exact both set");

	a_cplx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && complex_flag) |-> (larger_root == '0 && smaller_root == '0))
		else $error("complex result with nonzero roots");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !complex_flag) |-> (larger_root >= smaller_root))
		else $error("roots out of order");

endmodule

bind eigenvalues_2x2_integer_top eig2_checker u_eig2_checker (.*);

FILE: dv/tb_eigenvalues_2x2_integer_top.sv
// Testbench for eigenvalues_2x2_integer_top: streams directed and random 2x2 matrices,
// predicts both roots and flags per matrix and checks every done strobe in order.
// Depends on eig2_pkg and the eigenvalues_2x2_integer_top RTL.
`timescale 1ns / 1ps

typedef struct {
	logic signed [eig2_pkg::ENTRY_BITS-1:0] tl;
	logic signed [eig2_pkg::ENTRY_BITS-1:0] tr;
	logic signed [eig2_pkg::ENTRY_BITS-1:0] bl;
	logic signed [eig2_pkg::ENTRY_BITS-1:0] br;
} matrix_t;

typedef struct {
	logic signed [eig2_pkg::OUT_W-1:0] larger;
	logic signed [eig2_pkg::OUT_W-1:0] smaller;
	logic                              cplx;
	logic                              exact;
} roots_t;

class eigen_tracker;
	roots_t pending_roots[$];
	int     mismatch_count;

	function new();
		mismatch_count = 0;
	endfunction

	// bitwise integer square root, floor of the real root
	function longint int_root(longint v);
		longint r;
		longint cand;
		r = 0;
		for (int i = 30; i >= 0; i--) begin
			cand = r | (64'sd1 <<< i);
			if (cand * cand <= v)
				r = cand;
		end
		return r;
	endfunction

	function logic signed [eig2_pkg::OUT_W-1:0] clamp_root(longint v);
		longint hi_lim;
		longint lo_lim;
		hi_lim = (64'sd1 <<< (eig2_pkg::OUT_W - 1)) - 1;
		lo_lim = -(64'sd1 <<< (eig2_pkg::OUT_W - 1));
		if (v > hi_lim)
			v = hi_lim;
		if (v < lo_lim)
			v = lo_lim;
		return eig2_pkg::OUT_W'(v);
	endfunction

	function roots_t solve_roots(longint a, longint b, longint c, longint d);
		roots_t res;
		longint trace;
		longint det;
		longint disc;
		longint s;
		longint np;
		longint nm;
		longint hi_val;
		longint lo_val;
		trace  = a + d;
		det    = a * d - b * c;
		disc   = trace * trace - 4 * det;
		hi_val = 0;
		lo_val = 0;
		res.cplx  = 1'b0;
		res.exact = 1'b0;
		if (disc < 0) begin
			res.cplx = 1'b1;
		end else begin
			s  = int_root(disc);
			np = trace + s;
			nm = trace - s;
			if (s * s == disc) begin
				res.exact = 1'b1;
				hi_val = np / 2;
				lo_val = nm / 2;
			end else begin
				// true root lies strictly between s and s+1, so round by hand
				hi_val = (np >>> 1) + ((np < 0) ? 1 : 0);
				lo_val = ((nm - 1) >>> 1) + ((nm < 1) ? 1 : 0);
			end
		end
		res.larger  = clamp_root(hi_val);
		res.smaller = clamp_root(lo_val);
		return res;
	endfunction

	function void note_matrix(matrix_t m);
		pending_roots.push_back(solve_roots(m.tl, m.tr, m.bl, m.br));
	endfunction

	function void check_roots(roots_t got);
		roots_t want;
		if (pending_roots.size() == 0) begin
			$error("result transaction with no matrix pending");
			mismatch_count++;
			return;
		end
		want = pending_roots.pop_front();
		if (got.larger !== want.larger) begin
			$error("larger_root expected %0d got %0d", want.larger, got.larger);
			mismatch_count++;
		end
		if (got.smaller !== want.smaller) begin
			$error("smaller_root expected %0d got %0d", want.smaller, got.smaller);
			mismatch_count++;
		end
		if (got.cplx !== want.cplx) begin
			$error("complex_flag expected %0b got %0b", want.cplx, got.cplx);
			mismatch_count++;
		end
		if (got.exact !== want.exact) begin
			$error("exact_flag expected %0b got %0b", want.exact, got.exact);
			mismatch_count++;
		end
	endfunction
endclass

module tb_eigenvalues_2x2_integer_top;
	import eig2_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int QUIET_LIMIT  = 1000;
	localparam int MAX_GAP      = 12;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic signed [ENTRY_BITS-1:0] top_left;
	logic signed [ENTRY_BITS-1:0] top_right;
	logic signed [ENTRY_BITS-1:0] bottom_left;
	logic signed [ENTRY_BITS-1:0] bottom_right;
	logic                         done;
	logic signed [OUT_W-1:0]      larger_root;
	logic signed [OUT_W-1:0]      smaller_root;
	logic                         complex_flag;
	logic                         exact_flag;

	eigen_tracker root_tracker = new();
	int           idle_pct;
	int           quiet_cycles;

	eigenvalues_2x2_integer_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.top_left     (top_left),
		.top_right    (top_right),
		.bottom_left  (bottom_left),
		.bottom_right (bottom_right),
		.done         (done),
		.larger_root  (larger_root),
		.smaller_root (smaller_root),
		.complex_flag (complex_flag),
		.exact_flag   (exact_flag)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// monitor and watchdog, sampled on the rising edge
	always @(posedge clk) begin
		matrix_t m;
		roots_t  got;
		if (arst_n && start && !busy) begin
			m.tl = top_left;
			m.tr = top_right;
			m.bl = bottom_left;
			m.br = bottom_right;
			root_tracker.note_matrix(m);
		end
		if (arst_n && done) begin
			got.larger  = larger_root;
			got.smaller = smaller_root;
			got.cplx    = complex_flag;
			got.exact   = exact_flag;
			root_tracker.check_roots(got);
		end
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function matrix_t make_matrix(int a, int b, int c, int d);
		matrix_t m;
		m.tl = ENTRY_BITS'(a);
		m.tr = ENTRY_BITS'(b);
		m.bl = ENTRY_BITS'(c);
		m.br = ENTRY_BITS'(d);
		return m;
	endfunction

	function int extreme_entry();
		case ($urandom_range(0, 6))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			5: return 32766;
			default: return 32767;
		endcase
	endfunction

	function matrix_t random_matrix();
		matrix_t m;
		int      pick;
		int      base;
		pick = $urandom_range(0, 99);
		m = make_matrix($urandom, $urandom, $urandom, $urandom);
		if (pick < 30) begin
			// fully random entries
		end else if (pick < 50) begin
			// tiny entries hit zero and perfect-square discriminants often
			m = make_matrix(int'($urandom_range(0, 15)) - 8, int'($urandom_range(0, 15)) - 8,
				int'($urandom_range(0, 15)) - 8, int'($urandom_range(0, 15)) - 8);
		end else if (pick < 65) begin
			// symmetric: real roots, mostly irrational
			m.bl = m.tr;
		end else if (pick < 80) begin
			// triangular: exact roots equal to the diagonal
			if ($urandom_range(0, 1))
				m.bl = '0;
			else
				m.tr = '0;
		end else if (pick < 90) begin
			// near-equal diagonal with opposite off-diagonal signs leans complex
			base = int'($urandom_range(0, 65535)) - 32768;
			m = make_matrix(base, int'($urandom_range(1, 32767)),
				-int'($urandom_range(1, 32768)), base + int'($urandom_range(0, 63)) - 32);
		end else begin
			m = make_matrix(extreme_entry(), extreme_entry(), extreme_entry(), extreme_entry());
		end
		return m;
	endfunction

	task automatic send_matrix(matrix_t m);
		int gap;
		gap = 0;
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct && gap < MAX_GAP) begin
			@(negedge clk);
			start        <= 1'b0;
			top_left     <= ENTRY_BITS'($urandom);
			top_right    <= ENTRY_BITS'($urandom);
			bottom_left  <= ENTRY_BITS'($urandom);
			bottom_right <= ENTRY_BITS'($urandom);
			gap++;
		end
		@(negedge clk);
		start        <= 1'b1;
		top_left     <= m.tl;
		top_right    <= m.tr;
		bottom_left  <= m.bl;
		bottom_right <= m.br;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		top_left     = '0;
		top_right    = '0;
		bottom_left  = '0;
		bottom_right = '0;
		quiet_cycles = 0;
		idle_pct     = 34;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_matrix(make_matrix(0, 0, 0, 0));
		send_matrix(make_matrix(1, 0, 0, 1));
		send_matrix(make_matrix(1, 1, 1, 0));
		send_matrix(make_matrix(-1, 1, 1, 0));
		send_matrix(make_matrix(0, 1, 1, -1));
		send_matrix(make_matrix(0, -1, 1, 0));
		send_matrix(make_matrix(1, -1, 1, 1));
		send_matrix(make_matrix(0, 1, 1, 0));
		send_matrix(make_matrix(2, 1, 1, 2));
		send_matrix(make_matrix(1, 2, 3, 4));
		send_matrix(make_matrix(3, 0, 0, -5));
		send_matrix(make_matrix(-3, 0, 0, -4));
		send_matrix(make_matrix(0, 0, 0, -1));
		send_matrix(make_matrix(32767, 32767, 32767, 32767));
		send_matrix(make_matrix(-32768, -32768, -32768, -32768));
		send_matrix(make_matrix(32767, -32768, -32768, 32767));
		send_matrix(make_matrix(-32768, 32767, -32768, -32768));
		send_matrix(make_matrix(32767, 0, 0, -32768));
		send_matrix(make_matrix(-32768, -32768, 32767, 32767));
		send_matrix(make_matrix(-32768, 0, 0, -32768));
		send_matrix(make_matrix(0, 32767, 32767, 0));
		send_matrix(make_matrix(-32768, 32767, 32767, 32767));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// back-to-back stretch in the middle of the run
			idle_pct = (n >= 400 && n < 700) ? 0 : 34;
			send_matrix(random_matrix());
		end
		@(negedge clk);
		start <= 1'b0;

		@(posedge clk);
		while (root_tracker.pending_roots.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (root_tracker.mismatch_count == 0 && root_tracker.pending_roots.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
